>>> design/bsl_pkg.sv
// ----------------------------------------------------------------------------
// bsl_pkg: shared types and constants of the byte stream lexer
// Token kinds, scan modes, payload structs and the keyword table.
// ----------------------------------------------------------------------------
`default_nettype none
package bsl_pkg;

  localparam int KEYWORD_CHARS_DEF = 8;
  localparam int LINE_BITS_DEF     = 16;
  localparam int COLUMN_BITS_DEF   = 12;
  localparam int LEN_BITS          = 12;
  localparam int KIND_BITS         = 6;
  localparam int OUT_LINE_BITS     = 16;
  localparam int OUT_COL_BITS      = 12;
  localparam int NUM_KEYWORDS      = 18;
  localparam int KW_MAX_LEN        = 8;

  localparam logic [LEN_BITS-1:0] LENGTH_MAX = '1;

  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_BAR   = 8'h7c;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_NL    = 8'h0a;

  typedef enum logic [KIND_BITS-1:0] {
    K_FUNC = 6'd0, K_IDENT = 6'd18, K_INT = 6'd19, K_STRING = 6'd20,
    K_ASSIGN = 6'd21, K_EQEQ = 6'd22, K_NE = 6'd23, K_PLUS = 6'd24,
    K_MINUS = 6'd25, K_STAR = 6'd26, K_SLASH = 6'd27, K_PCT = 6'd28,
    K_LT = 6'd29, K_LE = 6'd30, K_GT = 6'd31, K_GE = 6'd32, K_AND = 6'd33,
    K_OR = 6'd34, K_NOT = 6'd35, K_LPAR = 6'd36, K_RPAR = 6'd37,
    K_LBRACE = 6'd38, K_RBRACE = 6'd39, K_SEMI = 6'd40, K_COLON = 6'd41,
    K_COMMA = 6'd42, K_INVALID = 6'd43, K_UNTERM = 6'd44, K_EOF = 6'd45
  } kind_t;

  typedef enum logic [2:0] {
    M_IDLE, M_IDENT, M_NUMBER, M_SIGN, M_OP, M_STR_OPEN, M_STR, M_ESC
  } mode_t;

  typedef struct packed {
    logic [7:0] source_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [KIND_BITS-1:0]     token_kind;
    logic [OUT_LINE_BITS-1:0] tok_line;
    logic [OUT_COL_BITS-1:0]  tok_col;
    logic [LEN_BITS-1:0]      token_length;
    logic                     last_of_run;
  } out_item_t;

  // one classified request handed from front to back: up to two tokens
  typedef struct packed {
    logic      first_vld;
    out_item_t first;
    logic      second_vld;
    out_item_t second;
  } pair_t;

  function automatic logic [8*KW_MAX_LEN-1:0] kw_text(input logic [4:0] k);
    case (k)
      5'd0:  kw_text = {"func", 32'h0};
      5'd1:  kw_text = {"if", 48'h0};
      5'd2:  kw_text = {"elif", 32'h0};
      5'd3:  kw_text = {"else", 32'h0};
      5'd4:  kw_text = {"return", 16'h0};
      5'd5:  kw_text = {"print", 24'h0};
      5'd6:  kw_text = {"for", 40'h0};
      5'd7:  kw_text = {"while", 24'h0};
      5'd8:  kw_text = {"break", 24'h0};
      5'd9:  kw_text = "continue";
      5'd10: kw_text = {"null", 32'h0};
      5'd11: kw_text = {"true", 32'h0};
      5'd12: kw_text = {"false", 24'h0};
      5'd13: kw_text = {"int", 40'h0};
      5'd14: kw_text = {"float", 24'h0};
      5'd15: kw_text = {"string", 16'h0};
      5'd16: kw_text = {"bool", 32'h0};
      5'd17: kw_text = {"void", 32'h0};
      default: kw_text = '0;
    endcase
  endfunction

  function automatic logic [3:0] kw_len(input logic [4:0] k);
    case (k)
      5'd0, 5'd2, 5'd3, 5'd10, 5'd11, 5'd16, 5'd17: kw_len = 4'd4;
      5'd1:                                         kw_len = 4'd2;
      5'd4, 5'd15:                                  kw_len = 4'd6;
      5'd5, 5'd7, 5'd8, 5'd12, 5'd14:               kw_len = 4'd5;
      5'd6, 5'd13:                                  kw_len = 4'd3;
      5'd9:                                         kw_len = 4'd8;
      default:                                      kw_len = 4'd0;
    endcase
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    is_letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = c >= "0" && c <= "9";
  endfunction

endpackage
`default_nettype wire

>>> design/byte_stream_lexer.sv
// ----------------------------------------------------------------------------
// byte_stream_lexer: byte-serial source lexer
// Channel  Dir  Payload
// in_      in   source_byte, end_of_input
// out_     out  token kind, start line/column, length, last_of_run
// One byte accepted per cycle while in_stall is low; the scanner state is registered.
// A byte that yields two tokens occupies the output for both, first then second.
// Results appear in the cycle after the byte at the earliest (queue read).
// Reset is synchronous; the two-entry queue fills before in_stall rises.
// ----------------------------------------------------------------------------
`default_nettype none
module byte_stream_lexer #(
  parameter int KEYWORD_CHARS = bsl_pkg::KEYWORD_CHARS_DEF,
  parameter int LINE_BITS     = bsl_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS   = bsl_pkg::COLUMN_BITS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire bsl_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output bsl_pkg::out_item_t     out_data
);
  import bsl_pkg::*;

  logic  req_vld, q_full, q_vld, q_take;
  pair_t req_data, q_data;

  bsl_front #(
    .KEYWORD_CHARS(KEYWORD_CHARS), .LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS)
  ) u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .req_vld, .req_full(q_full), .req_data
  );

  bsl_queue u_queue (
    .clk, .rst_n, .wr_vld(req_vld), .wr_data(req_data), .full(q_full),
    .rd_vld(q_vld), .rd_take(q_take), .rd_data(q_data)
  );

  bsl_back u_back (
    .clk, .rst_n, .rd_vld(q_vld), .rd_take(q_take), .rd_data(q_data),
    .out_valid, .out_stall, .out_data
  );

endmodule
`default_nettype wire

>>> design/bsl_front.sv
// ----------------------------------------------------------------------------
// bsl_front: scanner state and token classification
// Tracks position and scan mode, one byte per cycle unless the queue is full; emits up to two tokens.
// ----------------------------------------------------------------------------
`default_nettype none
module bsl_front #(
  parameter int KEYWORD_CHARS = bsl_pkg::KEYWORD_CHARS_DEF,
  parameter int LINE_BITS     = bsl_pkg::LINE_BITS_DEF,
  parameter int COLUMN_BITS   = bsl_pkg::COLUMN_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire bsl_pkg::in_item_t in_data,
  output logic                  req_vld,
  input  wire logic             req_full,
  output bsl_pkg::pair_t        req_data
);
  import bsl_pkg::*;

  localparam int KB = (KEYWORD_CHARS > 1) ? $clog2(KEYWORD_CHARS) : 1;

  mode_t                  mode_r, mode_nxt;
  logic [7:0]             pend_r, pend_nxt;
  logic [7:0]             kbuf_r [KEYWORD_CHARS];
  logic [7:0]             kbuf_nxt [KEYWORD_CHARS];
  logic [LEN_BITS-1:0]    run_r, run_nxt;
  logic [LINE_BITS-1:0]   tline_r, tline_nxt, cline_r, cline_nxt;
  logic [COLUMN_BITS-1:0] tcol_r, tcol_nxt, ccol_r, ccol_nxt;

  logic       acc;
  logic [7:0] c;
  logic       eoi;
  logic       e0, e1;
  out_item_t  t0, t1;
  logic [LEN_BITS-1:0] run_inc;
  logic [KIND_BITS-1:0] id_kind;

  assign in_stall = req_full;
  assign acc      = in_valid && !req_full;
  assign c        = in_data.source_byte;
  assign eoi      = in_data.end_of_input;
  assign run_inc  = (run_r == LENGTH_MAX) ? run_r : run_r + 1'b1;

  function automatic out_item_t mk(input logic [KIND_BITS-1:0] k,
                                   input logic [LINE_BITS-1:0] l,
                                   input logic [COLUMN_BITS-1:0] col,
                                   input logic [LEN_BITS-1:0] n);
    out_item_t o;
    o.token_kind   = k;
    o.tok_line     = OUT_LINE_BITS'(l);
    o.tok_col      = OUT_COL_BITS'(col);
    o.token_length = n;
    o.last_of_run  = 1'b0;
    return o;
  endfunction

  // parallel keyword compare
  always_comb begin
    logic same;
    logic [8*KW_MAX_LEN-1:0] kw_word;
    id_kind = K_IDENT;
    for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
      kw_word = kw_text(5'(k));
      same = (run_r == LEN_BITS'(kw_len(5'(k))));
      for (int i = 0; i < KW_MAX_LEN; i++) begin
        if (i < KEYWORD_CHARS && i < int'(kw_len(5'(k))))
          if (kbuf_r[i] != kw_word[8*(KW_MAX_LEN-1-i) +: 8]) same = 1'b0;
      end
      if (same) id_kind = KIND_BITS'(k);
    end
  end

  always_comb begin
    logic flush, fresh, f_emit;
    logic [KIND_BITS-1:0] fk, pk;
    out_item_t ft, st;
    mode_nxt  = mode_r;
    pend_nxt  = pend_r;
    kbuf_nxt  = kbuf_r;
    run_nxt   = run_r;
    tline_nxt = tline_r;
    tcol_nxt  = tcol_r;
    cline_nxt = cline_r;
    ccol_nxt  = ccol_r;
    flush = 1'b0;
    fresh = 1'b0;
    f_emit = 1'b0;
    fk = K_INVALID;
    pk = '0;
    ft = '0;
    st = '0;
    e0 = 1'b0;
    e1 = 1'b0;
    t0 = '0;
    t1 = '0;

    // pending token as it would flush now
    case (mode_r)
      M_IDENT:  begin f_emit = 1'b1; ft = mk(id_kind, tline_r, tcol_r, run_r); end
      M_NUMBER: begin f_emit = 1'b1; ft = mk(K_INT, tline_r, tcol_r, run_r); end
      M_SIGN: begin
        f_emit = 1'b1;
        ft = mk((pend_r == CH_PLUS) ? K_PLUS : K_MINUS, tline_r, tcol_r, LEN_BITS'(1));
      end
      M_OP: begin
        f_emit = 1'b1;
        case (pend_r)
          CH_EQ:   fk = K_ASSIGN;
          CH_BANG: fk = K_NOT;
          CH_LT:   fk = K_LT;
          CH_GT:   fk = K_GT;
          default: fk = K_INVALID;
        endcase
        ft = mk(fk, tline_r, tcol_r, LEN_BITS'(1));
      end
      M_STR_OPEN, M_STR, M_ESC: begin
        f_emit = 1'b1; ft = mk(K_UNTERM, tline_r, tcol_r, run_r);
      end
      default: f_emit = 1'b0;
    endcase

    if (eoi) begin
      e0 = f_emit;
      t0 = ft;
      e1 = 1'b1;
      t1 = mk(K_EOF, cline_r, ccol_r, '0);
      mode_nxt  = M_IDLE;
      pend_nxt  = '0;
      for (int i = 0; i < KEYWORD_CHARS; i++) kbuf_nxt[i] = '0;
      run_nxt   = '0;
      tline_nxt = LINE_BITS'(1);
      tcol_nxt  = '0;
      cline_nxt = LINE_BITS'(1);
      ccol_nxt  = '0;
    end else begin
      if (c == CH_NL) begin
        if (cline_r != '1) cline_nxt = cline_r + 1'b1;
        ccol_nxt = '0;
      end else if (ccol_r != '1) begin
        ccol_nxt = ccol_r + 1'b1;
      end

      case (mode_r)
        M_IDENT:
          if (is_letter(c) || is_digit(c)) begin
            if (run_r < LEN_BITS'(KEYWORD_CHARS)) kbuf_nxt[run_r[KB-1:0]] = c;
            run_nxt = run_inc;
          end else begin
            flush = 1'b1; fresh = 1'b1;
          end
        M_NUMBER:
          if (is_digit(c)) run_nxt = run_inc;
          else begin flush = 1'b1; fresh = 1'b1; end
        M_SIGN:
          if (is_digit(c)) begin run_nxt = LEN_BITS'(2); mode_nxt = M_NUMBER; end
          else begin flush = 1'b1; fresh = 1'b1; end
        M_OP: begin
          if (c == CH_EQ && pend_r == CH_EQ) pk = K_EQEQ;
          else if (c == CH_EQ && pend_r == CH_BANG) pk = K_NE;
          else if (c == CH_AMP && pend_r == CH_AMP) pk = K_AND;
          else if (c == CH_BAR && pend_r == CH_BAR) pk = K_OR;
          else if (c == CH_EQ && pend_r == CH_LT) pk = K_LE;
          else if (c == CH_EQ && pend_r == CH_GT) pk = K_GE;
          if (pk != '0) begin
            e0 = 1'b1;
            t0 = mk(pk, tline_r, tcol_r, LEN_BITS'(2));
            mode_nxt = M_IDLE;
          end else begin
            flush = 1'b1; fresh = 1'b1;
          end
        end
        M_STR_OPEN, M_STR: begin
          if (mode_r == M_STR_OPEN) begin
            tline_nxt = cline_nxt;
            tcol_nxt  = ccol_nxt;
            mode_nxt  = M_STR;
          end
          if (c == CH_QUOTE) begin
            e0 = 1'b1;
            t0 = mk(K_STRING, tline_nxt, tcol_nxt, run_r);
            mode_nxt = M_IDLE;
          end else begin
            run_nxt = run_inc;
            if (c == CH_BSL) mode_nxt = M_ESC;
          end
        end
        M_ESC: begin run_nxt = run_inc; mode_nxt = M_STR; end
        default: fresh = 1'b1;
      endcase

      if (flush) begin
        e0 = f_emit;
        t0 = ft;
      end

      if (fresh) begin
        mode_nxt = M_IDLE;
        if (c == " " || c == 8'h09 || c == 8'h0d || c == CH_NL) begin
          mode_nxt = M_IDLE;
        end else if (is_letter(c)) begin
          tline_nxt = cline_nxt; tcol_nxt = ccol_nxt;
          for (int i = 0; i < KEYWORD_CHARS; i++) kbuf_nxt[i] = '0;
          kbuf_nxt[0] = c;
          run_nxt = LEN_BITS'(1);
          mode_nxt = M_IDENT;
        end else if (is_digit(c)) begin
          tline_nxt = cline_nxt; tcol_nxt = ccol_nxt;
          run_nxt = LEN_BITS'(1);
          mode_nxt = M_NUMBER;
        end else if (c == CH_PLUS || c == CH_MINUS) begin
          tline_nxt = cline_nxt; tcol_nxt = ccol_nxt;
          pend_nxt = c;
          mode_nxt = M_SIGN;
        end else if (c == CH_QUOTE) begin
          tline_nxt = cline_nxt; tcol_nxt = ccol_nxt;
          run_nxt = '0;
          mode_nxt = M_STR_OPEN;
        end else if (c == CH_EQ || c == CH_BANG || c == CH_AMP || c == CH_BAR ||
                     c == CH_LT || c == CH_GT) begin
          tline_nxt = cline_nxt; tcol_nxt = ccol_nxt;
          pend_nxt = c;
          mode_nxt = M_OP;
        end else begin
          case (c)
            "*":     fk = K_STAR;
            "/":     fk = K_SLASH;
            "%":     fk = K_PCT;
            "(":     fk = K_LPAR;
            ")":     fk = K_RPAR;
            "{":     fk = K_LBRACE;
            "}":     fk = K_RBRACE;
            ";":     fk = K_SEMI;
            ":":     fk = K_COLON;
            ",":     fk = K_COMMA;
            default: fk = K_INVALID;
          endcase
          st = mk(fk, cline_nxt, ccol_nxt, LEN_BITS'(1));
          if (e0) begin e1 = 1'b1; t1 = st; end
          else begin e0 = 1'b1; t0 = st; end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_IDLE;
      pend_r  <= '0;
      for (int i = 0; i < KEYWORD_CHARS; i++) kbuf_r[i] <= '0;
      run_r   <= '0;
      tline_r <= LINE_BITS'(1);
      tcol_r  <= '0;
      cline_r <= LINE_BITS'(1);
      ccol_r  <= '0;
    end else if (acc) begin
      mode_r  <= mode_nxt;
      pend_r  <= pend_nxt;
      kbuf_r  <= kbuf_nxt;
      run_r   <= run_nxt;
      tline_r <= tline_nxt;
      tcol_r  <= tcol_nxt;
      cline_r <= cline_nxt;
      ccol_r  <= ccol_nxt;
    end
  end

  always_comb begin
    req_vld  = acc && (e0 || e1);
    req_data.first_vld  = e0;
    req_data.first      = t0;
    req_data.first.last_of_run = !e1;
    req_data.second_vld = e1;
    req_data.second     = t1;
    req_data.second.last_of_run = 1'b1;
  end

endmodule
`default_nettype wire

>>> design/bsl_queue.sv
// ----------------------------------------------------------------------------
// bsl_queue: two-entry request queue between front and back
// Holds classified token pairs so each side stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none
module bsl_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_vld,
  input  wire bsl_pkg::pair_t wr_data,
  output logic                full,
  output logic                rd_vld,
  input  wire logic           rd_take,
  output bsl_pkg::pair_t      rd_data
);
  import bsl_pkg::*;

  pair_t      mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign full    = cnt_r == 2'd2;
  assign rd_vld  = cnt_r != 2'd0;
  assign rd_data = mem_r[rp_r];
  assign wr      = wr_vld && !full;
  assign rd      = rd_take && rd_vld;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= !wp_r;
      if (rd) rp_r <= !rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule
`default_nettype wire

>>> design/bsl_back.sv
// ----------------------------------------------------------------------------
// bsl_back: token emitter
// Unpacks each queued request into one or two result tokens.
// ----------------------------------------------------------------------------
`default_nettype none
module bsl_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           rd_vld,
  output logic                rd_take,
  input  wire bsl_pkg::pair_t rd_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output bsl_pkg::out_item_t  out_data
);
  import bsl_pkg::*;

  // index of the token being shown: 0 = first (second if there is no first), 1 = second
  logic sel_r;
  logic cur_last;
  logic fire;

  assign out_valid = rd_vld;
  assign out_data  = (sel_r || !rd_data.first_vld) ? rd_data.second : rd_data.first;
  assign cur_last  = sel_r || !rd_data.first_vld || !rd_data.second_vld;
  assign fire      = rd_vld && !out_stall;
  assign rd_take   = fire && cur_last;

  always_ff @(posedge clk) begin
    if (!rst_n) sel_r <= 1'b0;
    else if (fire) sel_r <= !cur_last;
  end

endmodule
`default_nettype wire

>>> test/tb_byte_stream_lexer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_byte_stream_lexer: self-checking bench for the byte stream lexer
// Feeds directed and random source text, predicts every token with a local
// scanner model and compares each output request field by field, in order.
// ----------------------------------------------------------------------------
module tb_byte_stream_lexer;
  import bsl_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  byte_stream_lexer i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // scanner model state
  mode_t       sc_mode;
  logic [7:0]  sc_pend;
  logic [7:0]  sc_kwbuf [KEYWORD_CHARS_DEF];
  logic [11:0] sc_run;
  logic [15:0] sc_tok_line, sc_cur_line;
  logic [11:0] sc_tok_col, sc_cur_col;

  out_item_t token_queue [$];
  out_item_t step_tokens [$];
  int        error_count;
  int        checked_count;
  int        cycle_count;
  int        bytes_sent;
  bit        hold_off;
  bit        long_stall_req;

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d (token %0d)", what, got, want,
             checked_count);
    error_count++;
  endtask

  function automatic bit letter_c(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == CH_UNDER;
  endfunction

  function automatic bit digit_c(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  task automatic push_token(input kind_t k, input logic [15:0] ln,
                            input logic [11:0] col, input logic [11:0] len);
    out_item_t t;
    t.token_kind   = k;
    t.tok_line     = ln;
    t.tok_col      = col;
    t.token_length = len;
    t.last_of_run  = 1'b0;
    step_tokens.push_back(t);
  endtask

  function automatic kind_t word_kind();
    string words [NUM_KEYWORDS] = '{"func", "if", "elif", "else", "return", "print",
      "for", "while", "break", "continue", "null", "true", "false", "int", "float",
      "string", "bool", "void"};
    bit same;
    for (int k = 0; k < NUM_KEYWORDS; k++) begin
      same = sc_run == words[k].len() && words[k].len() <= KEYWORD_CHARS_DEF;
      for (int i = 0; same && i < words[k].len(); i++)
        if (sc_kwbuf[i] != words[k][i]) same = 1'b0;
      if (same) return kind_t'(k);
    end
    return K_IDENT;
  endfunction

  function automatic kind_t lone_op_kind(input logic [7:0] p);
    case (p)
      CH_EQ:   return K_ASSIGN;
      CH_BANG: return K_NOT;
      CH_LT:   return K_LT;
      CH_GT:   return K_GT;
      default: return K_INVALID;
    endcase
  endfunction

  task automatic clear_scanner();
    sc_mode = M_IDLE;
    sc_pend = '0;
    foreach (sc_kwbuf[i]) sc_kwbuf[i] = '0;
    sc_run = '0;
    sc_tok_line = 16'd1;
    sc_tok_col = '0;
    sc_cur_line = 16'd1;
    sc_cur_col = '0;
  endtask

  task automatic flush_token();
    case (sc_mode)
      M_IDENT:  push_token(word_kind(), sc_tok_line, sc_tok_col, sc_run);
      M_NUMBER: push_token(K_INT, sc_tok_line, sc_tok_col, sc_run);
      M_SIGN:   push_token(sc_pend == CH_PLUS ? K_PLUS : K_MINUS, sc_tok_line, sc_tok_col, 12'd1);
      M_OP:     push_token(lone_op_kind(sc_pend), sc_tok_line, sc_tok_col, 12'd1);
      M_STR_OPEN, M_STR, M_ESC: push_token(K_UNTERM, sc_tok_line, sc_tok_col, sc_run);
      default: ;
    endcase
    sc_mode = M_IDLE;
  endtask

  task automatic begin_token(input logic [7:0] c);
    kind_t k;
    sc_mode = M_IDLE;
    if (c == 8'h20 || c == 8'h09 || c == 8'h0d || c == CH_NL) return;
    sc_tok_line = sc_cur_line;
    sc_tok_col = sc_cur_col;
    if (letter_c(c)) begin
      foreach (sc_kwbuf[i]) sc_kwbuf[i] = '0;
      sc_kwbuf[0] = c;
      sc_run = 12'd1;
      sc_mode = M_IDENT;
    end else if (digit_c(c)) begin
      sc_run = 12'd1;
      sc_mode = M_NUMBER;
    end else if (c == CH_PLUS || c == CH_MINUS) begin
      sc_pend = c;
      sc_mode = M_SIGN;
    end else if (c == CH_QUOTE) begin
      sc_run = '0;
      sc_mode = M_STR_OPEN;
    end else if (c == CH_EQ || c == CH_BANG || c == CH_AMP || c == CH_BAR ||
                 c == CH_LT || c == CH_GT) begin
      sc_pend = c;
      sc_mode = M_OP;
    end else begin
      case (c)
        "*": k = K_STAR;
        "/": k = K_SLASH;
        "%": k = K_PCT;
        "(": k = K_LPAR;
        ")": k = K_RPAR;
        "{": k = K_LBRACE;
        "}": k = K_RBRACE;
        ";": k = K_SEMI;
        ":": k = K_COLON;
        ",": k = K_COMMA;
        default: k = K_INVALID;
      endcase
      push_token(k, sc_cur_line, sc_cur_col, 12'd1);
    end
  endtask

  function automatic kind_t pair_kind(input logic [7:0] p, input logic [7:0] c);
    if (p == CH_EQ && c == CH_EQ) return K_EQEQ;
    if (p == CH_BANG && c == CH_EQ) return K_NE;
    if (p == CH_AMP && c == CH_AMP) return K_AND;
    if (p == CH_BAR && c == CH_BAR) return K_OR;
    if (p == CH_LT && c == CH_EQ) return K_LE;
    if (p == CH_GT && c == CH_EQ) return K_GE;
    return K_FUNC;
  endfunction

  task automatic lex_request(input in_item_t req);
    logic [7:0] c;
    kind_t      k;
    c = req.source_byte;
    step_tokens.delete();
    if (req.end_of_input) begin
      flush_token();
      push_token(K_EOF, sc_cur_line, sc_cur_col, 12'd0);
      clear_scanner();
    end else begin
      if (c == CH_NL) begin
        if (sc_cur_line != 16'hffff) sc_cur_line++;
        sc_cur_col = '0;
      end else if (sc_cur_col != 12'hfff) begin
        sc_cur_col++;
      end
      case (sc_mode)
        M_IDENT:
          if (letter_c(c) || digit_c(c)) begin
            if (sc_run < KEYWORD_CHARS_DEF) sc_kwbuf[sc_run] = c;
            if (sc_run != LENGTH_MAX) sc_run++;
          end else begin
            flush_token();
            begin_token(c);
          end
        M_NUMBER:
          if (digit_c(c)) begin
            if (sc_run != LENGTH_MAX) sc_run++;
          end else begin
            flush_token();
            begin_token(c);
          end
        M_SIGN:
          if (digit_c(c)) begin
            sc_run = 12'd2;
            sc_mode = M_NUMBER;
          end else begin
            flush_token();
            begin_token(c);
          end
        M_OP: begin
          k = pair_kind(sc_pend, c);
          if (k != K_FUNC) begin
            push_token(k, sc_tok_line, sc_tok_col, 12'd2);
            sc_mode = M_IDLE;
          end else begin
            flush_token();
            begin_token(c);
          end
        end
        M_STR_OPEN, M_STR: begin
          if (sc_mode == M_STR_OPEN) begin
            sc_tok_line = sc_cur_line;
            sc_tok_col = sc_cur_col;
            sc_mode = M_STR;
          end
          if (c == CH_QUOTE) begin
            push_token(K_STRING, sc_tok_line, sc_tok_col, sc_run);
            sc_mode = M_IDLE;
          end else begin
            if (sc_run != LENGTH_MAX) sc_run++;
            if (c == CH_BSL) sc_mode = M_ESC;
          end
        end
        M_ESC: begin
          if (sc_run != LENGTH_MAX) sc_run++;
          sc_mode = M_STR;
        end
        default: begin_token(c);
      endcase
    end
    if (step_tokens.size() > 0) step_tokens[$].last_of_run = 1'b1;
    foreach (step_tokens[i]) token_queue.push_back(step_tokens[i]);
  endtask

  // most gaps short, a few long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // valid stays high after a request; drop it only when a gap or a wait follows
  task automatic send_item(input logic [7:0] b, input bit eoi, input bit gaps);
    in_item_t req;
    int       g;
    req.source_byte = b;
    req.end_of_input = eoi;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lex_request(req);
    bytes_sent++;
  endtask

  task automatic send_text(input string s, input bit gaps);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0, gaps);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (token_queue.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (token_queue.size() == 0) begin
        report_mismatch("unexpected kind", out_data.token_kind, -1);
      end else begin
        want = token_queue.pop_front();
        if (out_data.token_kind !== want.token_kind)
          report_mismatch("kind", out_data.token_kind, want.token_kind);
        if (out_data.tok_line !== want.tok_line)
          report_mismatch("line", out_data.tok_line, want.tok_line);
        if (out_data.tok_col !== want.tok_col)
          report_mismatch("column", out_data.tok_col, want.tok_col);
        if (out_data.token_length !== want.token_length)
          report_mismatch("length", out_data.token_length, want.token_length);
        if (out_data.last_of_run !== want.last_of_run)
          report_mismatch("last", out_data.last_of_run, want.last_of_run);
      end
      checked_count++;
    end
  end

  // receiver stalls, with one long hold-off on request
  always @(posedge clk) begin
    int stall_left;
    int long_left;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
      long_left = 0;
    end else if (long_stall_req && long_left == 0 && !hold_off) begin
      hold_off <= 1'b1;
      long_left = 60;
      out_stall <= 1'b1;
    end else if (long_left > 0) begin
      long_left--;
      if (long_left == 0) begin
        hold_off <= 1'b0;
        out_stall <= 1'b0;
      end
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= stall_left != 0;
    end else begin
      stall_left = gap_len();
      out_stall <= stall_left != 0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("tb_byte_stream_lexer: FAIL");
      $finish;
    end
  end

  task automatic test_keywords();
    send_text("func if elif else return print for while break continue null ", 1);
    send_text("true false int float string bool void iff _x9 continues\n", 1);
    send_item(8'h00, 1'b1, 1);
    drain();
  endtask

  task automatic test_operators();
    send_text("== != && || <= >= = < > ! & | + - +5 -12 a+b*/%(){};:,", 1);
    send_text("0123456789 =", 1);
    send_item(8'h0, 1'b1, 1);
    drain();
  endtask

  task automatic test_strings_and_odd_bytes();
    send_text("\"\" \"ab\\\"c\" \"x", 1);
    send_item(8'h0, 1'b1, 1);
    send_item(8'hff, 1'b0, 1);
    send_item(8'h80, 1'b0, 1);
    send_item(8'h00, 1'b0, 1);
    send_item(8'h7f, 1'b0, 1);
    send_text("\"", 1);
    send_item(8'h0, 1'b1, 1);
    send_item(8'h0, 1'b1, 1);
    drain();
  endtask

  task automatic test_long_runs();
    // long identifier, number and string, back to back
    send_item("a", 1'b0, 0);
    repeat (200) send_item("z", 1'b0, 0);
    send_text(" 7", 0);
    repeat (200) send_item("9", 1'b0, 0);
    send_item("\n", 1'b0, 0);
    send_item("\"", 1'b0, 0);
    repeat (150) send_item("q", 1'b0, 0);
    send_item(8'h0, 1'b1, 0);
    drain();
  endtask

  function automatic logic [7:0] pick_byte();
    string alpha = "abcdefilnorstuvw_XYZ0123456789+-=!<>&|*/%(){};:,\" \n\t\r\\";
    if ($urandom_range(0, 15) == 0) return 8'($urandom);
    return alpha[$urandom_range(0, alpha.len() - 1)];
  endfunction

  task automatic test_random_text();
    string words [8] = '{"while", "x_1", "return", "42", "-7", "\"s\\n\"", "<=", "&&"};
    int n;
    n = 0;
    while (n < 800) begin
      if ($urandom_range(0, 2) == 0) begin
        send_text(words[$urandom_range(0, 7)], 1);
        n += 3;
      end else begin
        send_item(pick_byte(), 1'b0, 1);
        n++;
      end
      if ($urandom_range(0, 120) == 0) send_item(8'($urandom), 1'b1, 1);
      if (n > 400 && n < 420 && !long_stall_req) long_stall_req = 1'b1;
      if (hold_off) long_stall_req = 1'b0;
    end
    long_stall_req = 1'b0;
    // back-to-back bytes while the receiver is held off, fill the queue
    in_valid <= 1'b0;
    long_stall_req = 1'b1;
    @(posedge clk);
    while (!hold_off) @(posedge clk);
    long_stall_req = 1'b0;
    repeat (30) send_item("+", 1'b0, 0);
    send_item(8'h0, 1'b1, 1);
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    hold_off = 1'b0;
    long_stall_req = 1'b0;
    error_count = 0;
    checked_count = 0;
    cycle_count = 0;
    bytes_sent = 0;
    clear_scanner();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_keywords();
    test_operators();
    test_strings_and_odd_bytes();
    test_random_text();
    test_long_runs();
    if (token_queue.size() != 0) begin
      $display("%0d tokens never arrived", token_queue.size());
      error_count++;
    end
    $display("sent %0d bytes: keywords, operators, strings, odd bytes, long runs",
             bytes_sent);
    $display("checked %0d tokens, %0d mismatches", checked_count, error_count);
    if (error_count == 0) begin
      $display("tb_byte_stream_lexer: PASS");
    end else begin
      $display("tb_byte_stream_lexer: FAIL");
    end
    $finish;
  end

endmodule
